// ===== src/two_door_airlock_interlock_macros.svh =====
`ifndef TWO_DOOR_AIRLOCK_INTERLOCK_MACROS_SVH
`define TWO_DOOR_AIRLOCK_INTERLOCK_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ALK_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("airlock assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ALK_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("airlock assertion failed");

`endif

// ===== src/alk_pkg.sv =====
package alk_pkg;

	localparam int TIMER_BITS = 20;
	localparam int CFG_W      = 20;
	localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
	localparam int REG_IDX_W  = 3;

	localparam logic [CMP_W-1:0] TMAX = CMP_W'({TIMER_BITS{1'b1}});

	typedef logic [TIMER_BITS-1:0] ticks_t;
	typedef logic [CFG_W-1:0]      preset_t;

	typedef enum logic [2:0] {
		MODE_CLOSED     = 3'd0,
		MODE_D1_OPENING = 3'd1,
		MODE_D1_OPEN    = 3'd2,
		MODE_D1_CLOSING = 3'd3,
		MODE_D2_OPENING = 3'd4,
		MODE_D2_OPEN    = 3'd5,
		MODE_D2_CLOSING = 3'd6,
		MODE_ERROR      = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		PH_OPENING = 2'd1,
		PH_OPEN    = 2'd2,
		PH_CLOSING = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		LAMP_OFF  = 2'd0,
		LAMP_SLOW = 2'd1,
		LAMP_FAST = 2'd2
	} lamp_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_OPENING_LIMIT = 3'd0,
		REG_AUTO_CLOSE    = 3'd1,
		REG_OPEN_LIMIT    = 3'd2,
		REG_CLOSING_LIMIT = 3'd3,
		REG_RESET_HOLD    = 3'd4
	} reg_idx_t;

	typedef struct packed {
		preset_t opening_limit;
		preset_t auto_close;
		preset_t open_limit;
		preset_t closing_limit;
		preset_t reset_hold;
	} cfg_t;

	typedef struct packed {
		logic d1_button_out;
		logic d1_button_in;
		logic d1_is_opened;
		logic d1_is_closed;
		logic d1_barrier_clear;
		logic d2_button_out;
		logic d2_button_in;
		logic d2_is_opened;
		logic d2_is_closed;
		logic d2_barrier_clear;
	} item_t;

	// motor bit 0 d1 open, 1 d1 close, 2 d2 open, 3 d2 close
	typedef struct packed {
		mode_t            mode;
		ticks_t [1:0]     et;
		logic [3:0]       motor;
		lamp_t [1:0]      lamp;
	} state_t;

	typedef struct packed {
		mode_t mode_code;
		logic  d1_drive_open;
		logic  d1_drive_close;
		logic  d2_drive_open;
		logic  d2_drive_close;
		lamp_t d1_lamp_mode;
		lamp_t d2_lamp_mode;
	} result_t;

	typedef struct packed {
		ticks_t et;
		logic   done;
	} ton_t;

	// On-delay timer tick: count saturates at the clipped preset.
	function automatic ton_t ton_step(ticks_t et, logic en, preset_t preset);
		logic [CMP_W-1:0] pt;
		logic [CMP_W-1:0] cur;
		ton_t r;
		pt = CMP_W'(preset);
		if (pt > TMAX) pt = TMAX;
		cur = CMP_W'(et);
		if (!en) begin
			r.et = '0;
			r.done = 1'b0;
		end else begin
			if (cur >= pt) cur = pt;
			else cur = CMP_W'(cur + 1'b1);
			r.et = cur[TIMER_BITS-1:0];
			r.done = (cur >= pt);
		end
		return r;
	endfunction

	function automatic mode_t door_mode(logic d, phase_t ph);
		mode_t m;
		unique case (ph)
			PH_OPENING: m = d ? MODE_D2_OPENING : MODE_D1_OPENING;
			PH_OPEN:    m = d ? MODE_D2_OPEN : MODE_D1_OPEN;
			default:    m = d ? MODE_D2_CLOSING : MODE_D1_CLOSING;
		endcase
		return m;
	endfunction

endpackage

// ===== src/alk_cfg.sv =====
module alk_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [alk_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [alk_pkg::CFG_W-1:0]     wr_data,
	output alk_pkg::cfg_t                 cfg
);
	import alk_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.opening_limit <= CFG_W'(10000);
			cfg_q.auto_close    <= CFG_W'(5000);
			cfg_q.open_limit    <= CFG_W'(30000);
			cfg_q.closing_limit <= CFG_W'(10000);
			cfg_q.reset_hold    <= CFG_W'(3000);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_OPENING_LIMIT: cfg_q.opening_limit <= wr_data;
				REG_AUTO_CLOSE:    cfg_q.auto_close <= wr_data;
				REG_OPEN_LIMIT:    cfg_q.open_limit <= wr_data;
				REG_CLOSING_LIMIT: cfg_q.closing_limit <= wr_data;
				REG_RESET_HOLD:    cfg_q.reset_hold <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/alk_step.sv =====
module alk_step (
	input  alk_pkg::cfg_t   cfg,
	input  alk_pkg::item_t  item,
	input  alk_pkg::state_t cur,
	output alk_pkg::state_t nxt
);
	import alk_pkg::*;

	always_comb begin
		logic   d;
		logic   btn, opened, closed, clear;
		logic   b1, b2;
		ton_t   t, t1, t2;
		logic [CMP_W-1:0] et_ext;

		nxt = cur;
		b1 = item.d1_button_out | item.d1_button_in;
		b2 = item.d2_button_out | item.d2_button_in;
		d = (cur.mode >= MODE_D2_OPENING);
		btn    = d ? b2 : b1;
		opened = d ? item.d2_is_opened : item.d1_is_opened;
		closed = d ? item.d2_is_closed : item.d1_is_closed;
		clear  = d ? item.d2_barrier_clear : item.d1_barrier_clear;
		t = '0;
		t1 = '0;
		t2 = '0;
		et_ext = '0;

		unique case (cur.mode) inside
			MODE_CLOSED: begin
				if (b1) begin
					nxt.et[0] = '0;
					nxt.mode = MODE_D1_OPENING;
				end else if (b2) begin
					nxt.et[1] = '0;
					nxt.mode = MODE_D2_OPENING;
				end
			end
			MODE_ERROR: begin
				nxt.motor = '0;
				nxt.lamp[0] = LAMP_FAST;
				nxt.lamp[1] = LAMP_FAST;
				t1 = ton_step(cur.et[0], item.d1_button_out, cfg.reset_hold);
				t2 = ton_step(cur.et[1], item.d2_button_out, cfg.reset_hold);
				nxt.et[0] = t1.et;
				nxt.et[1] = t2.et;
				if (t1.done || t2.done) begin
					nxt.lamp[0] = LAMP_OFF;
					nxt.lamp[1] = LAMP_OFF;
					// timer kept: closing limit counts on from the hold count
					if (item.d1_is_closed && item.d2_is_closed)
						nxt.mode = MODE_CLOSED;
					else if (!item.d1_is_closed && item.d2_is_closed)
						nxt.mode = MODE_D1_CLOSING;
					else if (item.d1_is_closed && !item.d2_is_closed)
						nxt.mode = MODE_D2_CLOSING;
				end
			end
			MODE_D1_OPENING, MODE_D2_OPENING: begin
				nxt.motor[{d, 1'b0}] = 1'b1;
				t = ton_step(cur.et[d], 1'b1, cfg.opening_limit);
				nxt.et[d] = t.et;
				if (opened) begin
					nxt.motor[{d, 1'b0}] = 1'b0;
					nxt.et[d] = '0;
					nxt.mode = door_mode(d, PH_OPEN);
				end else begin
					nxt.mode = t.done ? MODE_ERROR : door_mode(d, PH_OPENING);
				end
			end
			MODE_D1_OPEN, MODE_D2_OPEN: begin
				t = ton_step(cur.et[d], 1'b1, cfg.open_limit);
				nxt.et[d] = t.et;
				et_ext = CMP_W'(t.et);
				if (et_ext > CMP_W'(cfg.auto_close) && clear) begin
					nxt.et[d] = '0;
					nxt.mode = door_mode(d, PH_CLOSING);
				end else begin
					nxt.mode = t.done ? MODE_ERROR : door_mode(d, PH_OPEN);
				end
			end
			default: begin
				nxt.motor[{d, 1'b1}] = 1'b1;
				t = ton_step(cur.et[d], 1'b1, cfg.closing_limit);
				nxt.et[d] = t.et;
				nxt.lamp[d] = LAMP_SLOW;
				if (!clear || btn) begin
					// reopen
					nxt.motor[{d, 1'b1}] = 1'b0;
					nxt.lamp[d] = LAMP_OFF;
					nxt.et[d] = '0;
					nxt.mode = door_mode(d, PH_OPENING);
				end else if (closed) begin
					nxt.motor[{d, 1'b1}] = 1'b0;
					nxt.lamp[d] = LAMP_OFF;
					nxt.mode = MODE_CLOSED;
				end else begin
					nxt.mode = t.done ? MODE_ERROR : door_mode(d, PH_CLOSING);
				end
			end
		endcase
	end

endmodule

// ===== src/alk_out.sv =====
module alk_out (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  alk_pkg::result_t push_data,
	output logic             full,
	output logic             out_valid,
	input  logic             out_stall,
	output alk_pkg::result_t out_data
);
	import alk_pkg::*;

	// slot 0 drives the port, slot 1 is the skid entry
	logic    v0_q, v1_q;
	result_t d0_q, d1_q;
	logic    pop;

	assign pop = v0_q & ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else begin
			if (v1_q) begin
				if (pop) v1_q <= 1'b0;
			end else if (v0_q) begin
				if (push && !pop) v1_q <= 1'b1;
				if (!push && pop) v0_q <= 1'b0;
			end else if (push) begin
				v0_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v1_q) begin
			if (pop) d0_q <= d1_q;
		end else if (push) begin
			if (!v0_q || pop) d0_q <= push_data;
			else d1_q <= push_data;
		end
	end

	assign full = v1_q;
	assign out_valid = v0_q;
	assign out_data = d0_q;

endmodule

// ===== src/two_door_airlock_interlock.sv =====
// The input register takes an item; its result item is computed from it and
// written into the output buffer once that buffer has room.
// Throughput: one item per cycle; the input side stalls only while an item
// waits in the input register and the two-entry output buffer is full.
// Reset (arst_n low, asynchronous): mode closed, both timers zero, motors and
// lamps off, registers back to their defaults, no item in flight.
module two_door_airlock_interlock (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [alk_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [alk_pkg::CFG_W-1:0]     wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          d1_button_out,
	input  logic                          d1_button_in,
	input  logic                          d1_is_opened,
	input  logic                          d1_is_closed,
	input  logic                          d1_barrier_clear,
	input  logic                          d2_button_out,
	input  logic                          d2_button_in,
	input  logic                          d2_is_opened,
	input  logic                          d2_is_closed,
	input  logic                          d2_barrier_clear,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2:0]                    mode_code,
	output logic                          d1_drive_open,
	output logic                          d1_drive_close,
	output logic                          d2_drive_open,
	output logic                          d2_drive_close,
	output logic [1:0]                    d1_lamp_mode,
	output logic [1:0]                    d2_lamp_mode
);
	import alk_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	state_t  state_q, state_nxt;
	result_t res;
	result_t out_data;
	logic    full;
	logic    accept;
	logic    adv;

	alk_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	assign in_stall = valid_s1 & full;
	assign accept = in_valid & ~in_stall;
	assign adv = valid_s1 & ~full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else valid_s1 <= accept | (valid_s1 & full);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.d1_button_out    <= d1_button_out;
			item_s1.d1_button_in     <= d1_button_in;
			item_s1.d1_is_opened     <= d1_is_opened;
			item_s1.d1_is_closed     <= d1_is_closed;
			item_s1.d1_barrier_clear <= d1_barrier_clear;
			item_s1.d2_button_out    <= d2_button_out;
			item_s1.d2_button_in     <= d2_button_in;
			item_s1.d2_is_opened     <= d2_is_opened;
			item_s1.d2_is_closed     <= d2_is_closed;
			item_s1.d2_barrier_clear <= d2_barrier_clear;
		end
	end

	alk_step u_step (
		.cfg  (cfg),
		.item (item_s1),
		.cur  (state_q),
		.nxt  (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode  <= MODE_CLOSED;
			state_q.et    <= '0;
			state_q.motor <= '0;
			state_q.lamp  <= {LAMP_OFF, LAMP_OFF};
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		res.mode_code      = state_nxt.mode;
		res.d1_drive_open  = state_nxt.motor[0];
		res.d1_drive_close = state_nxt.motor[1];
		res.d2_drive_open  = state_nxt.motor[2];
		res.d2_drive_close = state_nxt.motor[3];
		res.d1_lamp_mode   = state_nxt.lamp[0];
		res.d2_lamp_mode   = state_nxt.lamp[1];
	end

	alk_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (adv),
		.push_data (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign mode_code      = out_data.mode_code;
	assign d1_drive_open  = out_data.d1_drive_open;
	assign d1_drive_close = out_data.d1_drive_close;
	assign d2_drive_open  = out_data.d2_drive_open;
	assign d2_drive_close = out_data.d2_drive_close;
	assign d1_lamp_mode   = out_data.d1_lamp_mode;
	assign d2_lamp_mode   = out_data.d2_lamp_mode;

endmodule

// ===== src/alk_checker.sv =====
`include "two_door_airlock_interlock_macros.svh"

module alk_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] mode_code,
	input logic       d1_drive_open,
	input logic       d1_drive_close,
	input logic       d2_drive_open,
	input logic       d2_drive_close,
	input logic [1:0] d1_lamp_mode,
	input logic [1:0] d2_lamp_mode
);
	import alk_pkg::*;

	logic        d1_moving, d2_moving;
	logic        lamps_off, any_fast, d1_busy;
	logic [10:0] res_bits;

	assign d1_moving = d1_drive_open | d1_drive_close;
	assign d2_moving = d2_drive_open | d2_drive_close;
	assign lamps_off = (d1_lamp_mode == LAMP_OFF) & (d2_lamp_mode == LAMP_OFF);
	assign any_fast = (d1_lamp_mode == LAMP_FAST) | (d2_lamp_mode == LAMP_FAST);
	assign d1_busy = (mode_code == MODE_D1_OPENING) | (mode_code == MODE_D1_OPEN) |
		(mode_code == MODE_D1_CLOSING);
	assign res_bits = {mode_code, d1_drive_open, d1_drive_close, d2_drive_open,
		d2_drive_close, d1_lamp_mode, d2_lamp_mode};

	// at most one door's motor runs
	`ALK_ASSERT_NOW(a_one_door_moves, out_valid, !(d1_moving && d2_moving))

	// airlock closed: motors and lamps off
	`ALK_ASSERT_NOW(a_closed_quiet, out_valid && mode_code == MODE_CLOSED, !d1_moving && !d2_moving && lamps_off)

	// door 1 in service leaves door 2 idle and dark
	`ALK_ASSERT_NOW(a_d2_idle, out_valid && d1_busy, !d2_moving && d2_lamp_mode == LAMP_OFF)

	// fast blink only while error holds, and then on both doors
	`ALK_ASSERT_NOW(a_error_lamps, out_valid && any_fast, mode_code == MODE_ERROR && d1_lamp_mode == d2_lamp_mode)

	`ALK_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(res_bits))

endmodule

bind two_door_airlock_interlock alk_checker u_alk_checker (.*);

// ===== bench/tb.sv =====
module tb;
	import alk_pkg::*;

	localparam int LIMIT = 300000;
	localparam int PHASE_ITEMS = 240;
	localparam int HOLD_CYCLES = 400;
	localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd5;
	localparam preset_t PRESET_TOP = '1;
	localparam result_t NO_RESULT = '0;

	typedef struct {
		int      cfg_sel;
		item_t   it;
		bit      typed;
		result_t res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [REG_IDX_W-1:0] wr_index = '0;
	preset_t wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	item_t cur = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] mode_code;
	logic d1_drive_open, d1_drive_close, d2_drive_open, d2_drive_close;
	logic [1:0] d1_lamp_mode, d2_lamp_mode;

	// predicted block state
	cfg_t cfg;
	mode_t pmode;
	ticks_t pet [2];
	logic [3:0] pmotor;
	lamp_t plamp [2];

	result_t awaited [$];
	row_t steps [$];
	cfg_t dir_cfg [2];
	int mismatches = 0;
	int cycles = 0;
	bit calm = 1'b0;
	int hold_asks = 0;
	int hold_seen = 0;
	int hold_left = 0;

	two_door_airlock_interlock dut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.d1_button_out(cur.d1_button_out),
		.d1_button_in(cur.d1_button_in),
		.d1_is_opened(cur.d1_is_opened),
		.d1_is_closed(cur.d1_is_closed),
		.d1_barrier_clear(cur.d1_barrier_clear),
		.d2_button_out(cur.d2_button_out),
		.d2_button_in(cur.d2_button_in),
		.d2_is_opened(cur.d2_is_opened),
		.d2_is_closed(cur.d2_is_closed),
		.d2_barrier_clear(cur.d2_barrier_clear),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.mode_code(mode_code),
		.d1_drive_open(d1_drive_open),
		.d1_drive_close(d1_drive_close),
		.d2_drive_open(d2_drive_open),
		.d2_drive_close(d2_drive_close),
		.d1_lamp_mode(d1_lamp_mode),
		.d2_lamp_mode(d2_lamp_mode)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic cfg_t make_cfg(int o, int a, int op, int c, int h);
		cfg_t r;
		r.opening_limit = preset_t'(o);
		r.auto_close = preset_t'(a);
		r.open_limit = preset_t'(op);
		r.closing_limit = preset_t'(c);
		r.reset_hold = preset_t'(h);
		return r;
	endfunction

	function automatic result_t outcome(mode_t m, logic [3:0] mot, lamp_t l1, lamp_t l2);
		result_t r;
		r.mode_code = m;
		r.d1_drive_open = mot[0];
		r.d1_drive_close = mot[1];
		r.d2_drive_open = mot[2];
		r.d2_drive_close = mot[3];
		r.d1_lamp_mode = l1;
		r.d2_lamp_mode = l2;
		return r;
	endfunction

	// on-delay count: saturates at the preset, zero while disabled
	function automatic ticks_t timer_next(ticks_t cnt, logic en, preset_t preset,
			output logic hit);
		if (!en) begin
			hit = 1'b0;
			return '0;
		end
		if (cnt >= preset)
			cnt = preset;
		else
			cnt = cnt + 1'b1;
		hit = (cnt >= preset);
		return cnt;
	endfunction

	task automatic door_tick(input bit d, input mode_t m, input logic btn, opened, closed,
			clear, output mode_t nxt);
		logic [2:0] rel;
		logic hit;
		int mo, mc;
		mode_t m_opening, m_open, m_closing;
		mo = d ? 2 : 0;
		mc = mo + 1;
		m_opening = d ? MODE_D2_OPENING : MODE_D1_OPENING;
		m_open = d ? MODE_D2_OPEN : MODE_D1_OPEN;
		m_closing = d ? MODE_D2_CLOSING : MODE_D1_CLOSING;
		rel = d ? m - MODE_D1_CLOSING : m;
		case (rel[1:0])
			PH_OPENING: begin
				pmotor[mo] = 1'b1;
				pet[d] = timer_next(pet[d], 1'b1, cfg.opening_limit, hit);
				if (opened) begin
					pmotor[mo] = 1'b0;
					pet[d] = '0;
					nxt = m_open;
				end else
					nxt = hit ? MODE_ERROR : m_opening;
			end
			PH_OPEN: begin
				pet[d] = timer_next(pet[d], 1'b1, cfg.open_limit, hit);
				if (pet[d] > cfg.auto_close && clear) begin
					pet[d] = '0;
					nxt = m_closing;
				end else
					nxt = hit ? MODE_ERROR : m_open;
			end
			default: begin
				pmotor[mc] = 1'b1;
				pet[d] = timer_next(pet[d], 1'b1, cfg.closing_limit, hit);
				plamp[d] = LAMP_SLOW;
				if (!clear || btn) begin
					pmotor[mc] = 1'b0;
					plamp[d] = LAMP_OFF;
					pet[d] = '0;
					nxt = m_opening;
				end else if (closed) begin
					pmotor[mc] = 1'b0;
					plamp[d] = LAMP_OFF;
					nxt = MODE_CLOSED;
				end else
					nxt = hit ? MODE_ERROR : m_closing;
			end
		endcase
	endtask

	task automatic airlock_tick(input item_t it, output result_t r);
		logic q1, q2;
		mode_t nxt;
		case (pmode)
			MODE_CLOSED: begin
				if (it.d1_button_out || it.d1_button_in) begin
					pet[0] = '0;
					pmode = MODE_D1_OPENING;
				end else if (it.d2_button_out || it.d2_button_in) begin
					pet[1] = '0;
					pmode = MODE_D2_OPENING;
				end
			end
			MODE_ERROR: begin
				pmotor = '0;
				plamp[0] = LAMP_FAST;
				plamp[1] = LAMP_FAST;
				pet[0] = timer_next(pet[0], it.d1_button_out, cfg.reset_hold, q1);
				pet[1] = timer_next(pet[1], it.d2_button_out, cfg.reset_hold, q2);
				if (q1 || q2) begin
					// with neither door closed the hold is taken but error stays
					plamp[0] = LAMP_OFF;
					plamp[1] = LAMP_OFF;
					if (it.d1_is_closed && it.d2_is_closed)
						pmode = MODE_CLOSED;
					else if (!it.d1_is_closed && it.d2_is_closed)
						pmode = MODE_D1_CLOSING;
					else if (it.d1_is_closed && !it.d2_is_closed)
						pmode = MODE_D2_CLOSING;
				end
			end
			MODE_D1_OPENING, MODE_D1_OPEN, MODE_D1_CLOSING: begin
				door_tick(1'b0, pmode, it.d1_button_out || it.d1_button_in, it.d1_is_opened,
					it.d1_is_closed, it.d1_barrier_clear, nxt);
				pmode = nxt;
			end
			default: begin
				door_tick(1'b1, pmode, it.d2_button_out || it.d2_button_in, it.d2_is_opened,
					it.d2_is_closed, it.d2_barrier_clear, nxt);
				pmode = nxt;
			end
		endcase
		r = outcome(pmode, pmotor, plamp[0], plamp[1]);
	endtask

	// plausible switch readings for one door, given the mode
	function automatic logic [4:0] door_bits(mode_t m, bit d);
		logic [1:0] ph;
		int pb;
		logic bo, bi, op, cl, clr;
		ph = '0;
		if (!d && m >= MODE_D1_OPENING && m <= MODE_D1_CLOSING)
			ph = 2'(m);
		if (d && m >= MODE_D2_OPENING && m <= MODE_D2_CLOSING)
			ph = 2'(m - MODE_D1_CLOSING);
		pb = (m == MODE_CLOSED) ? 25 : 6;
		bo = $urandom_range(99) < ((m == MODE_ERROR) ? 60 : pb);
		bi = $urandom_range(99) < pb;
		clr = $urandom_range(9) != 0;
		case (ph)
			PH_OPENING: begin
				op = $urandom_range(5) == 0;
				cl = 1'b0;
			end
			PH_OPEN: begin
				op = $urandom_range(19) != 0;
				cl = 1'b0;
			end
			PH_CLOSING: begin
				op = 1'b0;
				cl = $urandom_range(5) == 0;
			end
			default: begin
				cl = $urandom_range(3) != 0;
				op = !cl && $urandom_range(1);
			end
		endcase
		return {bo, bi, op, cl, clr};
	endfunction

	function automatic item_t make_item(mode_t m);
		logic [9:0] raw;
		if ($urandom_range(99) < 12)
			raw = 10'($urandom);
		else
			raw = {door_bits(m, 1'b0), door_bits(m, 1'b1)};
		return raw;
	endfunction

	function automatic void add_step(int sel, logic [9:0] bits, bit typed, result_t r);
		row_t s;
		s.cfg_sel = sel;
		s.it = bits;
		s.typed = typed;
		s.res = r;
		steps.push_back(s);
	endfunction

	task automatic reg_write(logic [REG_IDX_W-1:0] idx, preset_t v);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= v;
		@(posedge clk);
	endtask

	task automatic load_cfg(input cfg_t c, input bit spare);
		int i;
		// indexes past the last register must be ignored
		if (spare)
			for (i = 0; i < 3; i++)
				reg_write(REG_IDX_W'(REG_SPARE + i), preset_t'($urandom));
		reg_write(REG_OPENING_LIMIT, c.opening_limit);
		reg_write(REG_AUTO_CLOSE, c.auto_close);
		reg_write(REG_OPEN_LIMIT, c.open_limit);
		reg_write(REG_CLOSING_LIMIT, c.closing_limit);
		reg_write(REG_RESET_HOLD, c.reset_hold);
		wr_en <= 1'b0;
		cfg = c;
	endtask

	// called just after a rising edge; returns at the edge that took the item
	task automatic offer(input item_t it, input bit typed, input result_t res);
		result_t pred;
		while (!calm && $urandom_range(99) < 28) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		cur <= it;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		airlock_tick(it, pred);
		awaited.push_back(typed ? res : pred);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (awaited.size() != 0);
	endtask

	always @(posedge clk) begin
		if (hold_asks != hold_seen) begin
			hold_seen = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else if (calm)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(99) < 28);
	end

	function automatic int field_diff(string name, int want, int got);
		if (want == got)
			return 0;
		$display("%0t %s: expected %0d, got %0d", $time, name, want, got);
		return 1;
	endfunction

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited.size() == 0) begin
				$display("%0t result item with none expected: mode_code %0d", $time, mode_code);
				mismatches++;
			end else begin
				want = awaited.pop_front();
				mismatches += field_diff("mode_code", want.mode_code, mode_code)
					+ field_diff("d1_drive_open", want.d1_drive_open, d1_drive_open)
					+ field_diff("d1_drive_close", want.d1_drive_close, d1_drive_close)
					+ field_diff("d2_drive_open", want.d2_drive_open, d2_drive_open)
					+ field_diff("d2_drive_close", want.d2_drive_close, d2_drive_close)
					+ field_diff("d1_lamp_mode", want.d1_lamp_mode, d1_lamp_mode)
					+ field_diff("d2_lamp_mode", want.d2_lamp_mode, d2_lamp_mode);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin : stimulus
		cfg_t c;
		int k, n, ol;
		cfg = make_cfg(10000, 5000, 30000, 10000, 3000);
		pmode = MODE_CLOSED;
		pet[0] = '0;
		pet[1] = '0;
		pmotor = '0;
		plamp[0] = LAMP_OFF;
		plamp[1] = LAMP_OFF;
		dir_cfg[0] = make_cfg(3, 1, 6, 3, 2);
		// auto close above the open limit, zero reset hold
		dir_cfg[1] = make_cfg(3, 6, 2, 3, 0);

		// bits: b_out b_in opened closed clear, door 1 then door 2
		add_step(-1, 10'b00011_00011, 1, outcome(MODE_CLOSED, 4'b0000, LAMP_OFF, LAMP_OFF));
		add_step(-1, 10'b11011_11011, 1, outcome(MODE_D1_OPENING, 4'b0000, LAMP_OFF, LAMP_OFF));
		add_step(-1, 10'b00001_00011, 1, outcome(MODE_D1_OPENING, 4'b0001, LAMP_OFF, LAMP_OFF));
		add_step(-1, 10'b00101_00011, 1, outcome(MODE_D1_OPEN, 4'b0000, LAMP_OFF, LAMP_OFF));
		add_step(0, 10'b00100_00011, 0, NO_RESULT);
		add_step(-1, 10'b00101_00011, 0, NO_RESULT);
		add_step(-1, 10'b00001_00011, 0, NO_RESULT);
		add_step(-1, 10'b00000_00011, 0, NO_RESULT);
		add_step(-1, 10'b00001_00011, 0, NO_RESULT);
		add_step(-1, 10'b00001_00011, 0, NO_RESULT);
		add_step(-1, 10'b00001_00011, 0, NO_RESULT);
		add_step(-1, 10'b00001_00011, 1, outcome(MODE_ERROR, 4'b0000, LAMP_FAST, LAMP_FAST));
		add_step(-1, 10'b10000_10000, 1, outcome(MODE_ERROR, 4'b0000, LAMP_FAST, LAMP_FAST));
		add_step(-1, 10'b10000_10000, 1, outcome(MODE_ERROR, 4'b0000, LAMP_OFF, LAMP_OFF));
		add_step(-1, 10'b10000_00011, 0, NO_RESULT);
		add_step(-1, 10'b00001_00011, 0, NO_RESULT);
		add_step(-1, 10'b10011_00011, 0, NO_RESULT);
		add_step(-1, 10'b00011_11011, 0, NO_RESULT);
		add_step(-1, 10'b00011_00001, 0, NO_RESULT);
		add_step(-1, 10'b00011_00101, 0, NO_RESULT);
		add_step(-1, 10'b00011_00101, 0, NO_RESULT);
		add_step(-1, 10'b00011_00101, 0, NO_RESULT);
		add_step(-1, 10'b00011_00011, 0, NO_RESULT);
		add_step(1, 10'b01011_00011, 0, NO_RESULT);
		add_step(-1, 10'b00101_00011, 0, NO_RESULT);
		add_step(-1, 10'b00101_00011, 0, NO_RESULT);
		add_step(-1, 10'b00101_00011, 0, NO_RESULT);
		add_step(-1, 10'b10011_00011, 0, NO_RESULT);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (steps[i]) begin
			if (steps[i].cfg_sel >= 0) begin
				drain();
				load_cfg(dir_cfg[steps[i].cfg_sel], 1'b0);
			end
			offer(steps[i].it, steps[i].typed, steps[i].res);
		end

		for (k = 0; k < 8; k++) begin
			drain();
			case (k)
				0: c = make_cfg(1, 0, 1, 1, 0);
				1: c = make_cfg(PRESET_TOP, PRESET_TOP, PRESET_TOP, PRESET_TOP, PRESET_TOP);
				4: begin
					ol = $urandom_range(8, 1);
					c = make_cfg($urandom_range(12, 1), ol + $urandom_range(4, 0), ol,
						$urandom_range(12, 1), $urandom_range(6, 0));
				end
				default: c = make_cfg($urandom_range(12, 1), $urandom_range(10, 0),
					$urandom_range(20, 1), $urandom_range(12, 1), $urandom_range(6, 0));
			endcase
			load_cfg(c, k == 5);
			calm = (k == 3);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// long receiver hold-off so the block backs up into its input
				if (k == 2 && n == 30)
					hold_asks++;
				if (k == 4 && n == 120)
					drain();
				offer(make_item(pmode), 1'b0, NO_RESULT);
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== two_door_airlock_interlock.f =====
+incdir+src
src/alk_pkg.sv
src/alk_cfg.sv
src/alk_step.sv
src/alk_out.sv
src/two_door_airlock_interlock.sv
src/alk_checker.sv
bench/tb.sv
